@@ rtl/rgb565_run_length_encoder_core_assert.svh @@
// assertion macros shared by the rgb565 run-length encoder rtl
`ifndef RGB565_RUN_LENGTH_ENCODER_CORE_ASSERT_SVH
`define RGB565_RUN_LENGTH_ENCODER_CORE_ASSERT_SVH

// same-cycle implication, held off while reset is high
`define RLE565_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off while reset is high
`define RLE565_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/rle565_pkg.sv @@
// shared types and constants of the rgb565 run-length encoder
`timescale 1ns / 1ps
`default_nettype none

package rle565_pkg;

   localparam int COLOR_W     = 16;
   localparam int LEN_W       = 8;
   localparam int BYTES_W     = 24;
   localparam int REC_BYTES   = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   // value of paddr[2] that selects output_capacity
   localparam logic CSR_SEL_CAPACITY = 1'b0;

   localparam logic [BYTES_W-1:0] CAPACITY_RESET = '1;

   // one result beat
   typedef struct packed {
      logic [LEN_W-1:0]   len;
      logic [COLOR_W-1:0] color;
      logic               done;
      logic               ovf;
      logic [BYTES_W-1:0] total;
   } rec_type;

   // one queue entry: the results caused by one pixel
   typedef struct packed {
      rec_type rec_a;
      rec_type rec_b;
      logic    two;
   } entry_type;

endpackage

`default_nettype wire

@@ rtl/rgb565_run_length_encoder_core.sv @@
// top level of the rgb565 run-length encoder: pixel stream in, run records out.
// pixels enter on req_ at up to one beat per clock; each beat is a 16-bit color
// plus a frame_end flag. runs of equal color, at most MAX_RUN pixels long, are
// reported on rsp_ as one beat per three-byte record (count, color low, color
// high). the last beat of a frame carries frame_done and the frame's byte total,
// or overflow with length and total zero when output_capacity would be passed.
// the front end decides every result in the cycle it accepts a pixel and writes
// them as one entry into a four-entry queue; the back end hands them out one
// beat per clock while rsp_ready allows, from an output register. a pixel that
// both closes a run and ends the frame gives two beats on rsp_, so only the
// rsp_ port's one beat per clock sets the sustained rate. the queue slot and
// then the output register lie between the edge that accepts a pixel and the
// first result it causes. output_capacity sits at byte address 0 of the apb
// port, resets to 0xffffff and should only be changed between frames while no
// beat is in flight.
`timescale 1ns / 1ps
`default_nettype none

module rgb565_run_length_encoder_core #(
   parameter int MAX_RUN = 255
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // pixel channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [rle565_pkg::COLOR_W-1:0]       req_pixel_color,
   input  logic                                 req_frame_end,
   // record channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [rle565_pkg::LEN_W-1:0]         rsp_run_length,
   output logic [rle565_pkg::COLOR_W-1:0]       rsp_run_color,
   output logic                                 rsp_frame_done,
   output logic                                 rsp_overflow,
   output logic [rle565_pkg::BYTES_W-1:0]       rsp_total_bytes,
   // apb register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rle565_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rle565_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [rle565_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                 pready
);
   import rle565_pkg::*;

   // register file: only output_capacity
   logic [BYTES_W-1:0] capacity_ff, capacity_in;
   logic               csr_write;
   logic               csr_hit;

   // front/back coupling
   entry_type          push_entry, head_entry;
   logic               q_push, q_pop, q_full, q_empty;
   rec_type            out_rec;

   // beat shape checks
   logic               ovf_beat, ovf_shape_ok;
   logic               mid_beat, mid_shape_ok;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_W-1] == CSR_SEL_CAPACITY);
   assign csr_write = psel & penable & pwrite & csr_hit;

   // write lands in the access phase, upper byte of pwdata is dropped
   assign capacity_in = csr_write ? pwdata[BYTES_W-1:0] : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // reads of unmapped addresses return zero
   assign prdata = csr_hit ? {{(CSR_DATA_W-BYTES_W){1'b0}}, capacity_ff} : '0;

   // run tracking and byte accounting, one pixel a cycle while the queue has room
   rle565_front #(
      .MAX_RUN (MAX_RUN)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .in_pixel_color (req_pixel_color),
      .in_frame_end   (req_frame_end),
      .capacity       (capacity_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   // absorbs double-result pixels and output stalls
   rle565_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   // one record beat per clock out of the queue while rsp_ready allows
   rle565_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (head_entry),
      .q_pop     (q_pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rec   (out_rec)
   );

   assign rsp_run_length  = out_rec.len;
   assign rsp_run_color   = out_rec.color;
   assign rsp_frame_done  = out_rec.done;
   assign rsp_overflow    = out_rec.ovf;
   assign rsp_total_bytes = out_rec.total;

   assign ovf_beat     = rsp_valid & rsp_overflow;
   assign ovf_shape_ok = rsp_frame_done && rsp_run_length == '0 && rsp_total_bytes == '0;
   assign mid_beat     = rsp_valid & ~rsp_frame_done;
   assign mid_shape_ok = rsp_run_length != '0 && rsp_total_bytes == '0 && !rsp_overflow;

`include "rgb565_run_length_encoder_core_assert.svh"

   // an overflow beat is always the empty final one
   `RLE565_ASSERT_IMPL(a_ovf_beat_empty, clock, reset, ovf_beat, ovf_shape_ok, "bad overflow beat")
   // mid-frame records hold a real run and no total
   `RLE565_ASSERT_IMPL(a_mid_record_shape, clock, reset, mid_beat, mid_shape_ok, "bad mid record")

endmodule

`default_nettype wire

@@ rtl/rle565_front.sv @@
// front end: run tracking, capacity accounting and result formation per pixel
`timescale 1ns / 1ps
`default_nettype none

module rle565_front #(
   parameter int MAX_RUN = 255
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [rle565_pkg::COLOR_W-1:0]    in_pixel_color,
   input  logic                              in_frame_end,
   input  logic [rle565_pkg::BYTES_W-1:0]    capacity,
   input  logic                              q_full,
   output logic                              q_push,
   output rle565_pkg::entry_type             q_entry
);
   import rle565_pkg::*;

   logic               active_ff, active_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [LEN_W-1:0]   count_ff, count_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic               ovf_ff, ovf_in;

   logic               accept;
   logic [BYTES_W:0]   sum_one, sum_two, cap_x;
   logic               fit_one, fit_two, fit_last;
   logic               match, emit_run, rec0;
   logic               ovf_a, last_ok;
   logic [BYTES_W-1:0] bytes_a, total_last;
   logic               active_a;
   logic [COLOR_W-1:0] color_a;
   logic [LEN_W-1:0]   count_a;
   rec_type            run_rec, final_rec;

   assign in_ready = ~q_full;
   assign accept   = in_valid & ~q_full;

   // one record more and two records more, compared side by side
   assign cap_x   = {1'b0, capacity};
   assign sum_one = {1'b0, bytes_ff} + (BYTES_W+1)'(REC_BYTES);
   assign sum_two = {1'b0, bytes_ff} + (BYTES_W+1)'(2 * REC_BYTES);
   assign fit_one = (sum_one <= cap_x);
   assign fit_two = (sum_two <= cap_x);

   assign match    = (in_pixel_color == color_ff) && (count_ff < LEN_W'(MAX_RUN));
   assign emit_run = ~ovf_ff & active_ff & ~match;
   assign rec0     = emit_run & fit_one;
   assign ovf_a    = ovf_ff | (emit_run & ~fit_one);
   assign bytes_a  = rec0 ? sum_one[BYTES_W-1:0] : bytes_ff;

   assign fit_last   = rec0 ? fit_two : fit_one;
   assign total_last = rec0 ? sum_two[BYTES_W-1:0] : sum_one[BYTES_W-1:0];
   assign last_ok    = ~ovf_a & fit_last;

   always_comb begin
      active_a = active_ff;
      color_a  = color_ff;
      count_a  = count_ff;
      if (!ovf_ff) begin
         active_a = 1'b1;
         if (active_ff && match) begin
            count_a = count_ff + LEN_W'(1);
         end else begin
            color_a = in_pixel_color;
            count_a = LEN_W'(1);
         end
      end
   end

   always_comb begin
      run_rec.len   = count_ff;
      run_rec.color = color_ff;
      run_rec.done  = 1'b0;
      run_rec.ovf   = 1'b0;
      run_rec.total = '0;
      if (last_ok) begin
         final_rec.len   = count_a;
         final_rec.color = color_a;
         final_rec.done  = 1'b1;
         final_rec.ovf   = 1'b0;
         final_rec.total = total_last;
      end else begin
         final_rec.len   = '0;
         final_rec.color = '0;
         final_rec.done  = 1'b1;
         final_rec.ovf   = 1'b1;
         final_rec.total = '0;
      end
   end

   always_comb begin
      if (rec0) begin
         q_entry.rec_a = run_rec;
         q_entry.rec_b = final_rec;
         q_entry.two   = in_frame_end;
      end else begin
         q_entry.rec_a = final_rec;
         q_entry.rec_b = final_rec;
         q_entry.two   = 1'b0;
      end
   end

   assign q_push = accept & (rec0 | in_frame_end);

   always_comb begin
      active_in = active_ff;
      color_in  = color_ff;
      count_in  = count_ff;
      bytes_in  = bytes_ff;
      ovf_in    = ovf_ff;
      if (accept) begin
         if (in_frame_end) begin
            active_in = 1'b0;
            color_in  = '0;
            count_in  = '0;
            bytes_in  = '0;
            ovf_in    = 1'b0;
         end else begin
            active_in = active_a;
            color_in  = color_a;
            count_in  = count_a;
            bytes_in  = bytes_a;
            ovf_in    = ovf_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         color_ff  <= '0;
         count_ff  <= '0;
         bytes_ff  <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         active_ff <= active_in;
         color_ff  <= color_in;
         count_ff  <= count_in;
         bytes_ff  <= bytes_in;
         ovf_ff    <= ovf_in;
      end
   end

`include "rgb565_run_length_encoder_core_assert.svh"

   `RLE565_ASSERT_NEXT(a_frame_end_clears, clock, reset, accept && in_frame_end, !active_ff && bytes_ff == '0 && !ovf_ff, "frame state not cleared after frame end")

endmodule

`default_nettype wire

@@ rtl/rle565_queue.sv @@
// short entry queue between the front end and the result side
`timescale 1ns / 1ps
`default_nettype none

module rle565_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rle565_pkg::entry_type push_entry,
   input  logic                  pop,
   output rle565_pkg::entry_type head_entry,
   output logic                  full,
   output logic                  empty
);
   import rle565_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'((int'(wr_ptr_ff) + 1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'((int'(rd_ptr_ff) + 1) % QUEUE_DEPTH) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`include "rgb565_run_length_encoder_core_assert.svh"

   `RLE565_ASSERT_IMPL(a_no_push_when_full, clock, reset, push, !full, "queue written while full")
   `RLE565_ASSERT_IMPL(a_no_pop_when_empty, clock, reset, pop, !empty, "queue read while empty")

endmodule

`default_nettype wire

@@ rtl/rle565_back.sv @@
// result side: unpacks queue entries into single result beats
`timescale 1ns / 1ps
`default_nettype none

module rle565_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  rle565_pkg::entry_type q_head,
   output logic                  q_pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rle565_pkg::rec_type   out_rec
);
   import rle565_pkg::*;

   logic    valid_ff, valid_in;
   logic    pend_ff, pend_in;
   rec_type rec_ff, rec_in;
   rec_type pend_rec_ff, pend_rec_in;
   logic    load;

   // output slot is free or its beat leaves this cycle
   assign load  = ~valid_ff | out_ready;
   assign q_pop = load & ~pend_ff & ~q_empty;

   always_comb begin
      valid_in    = valid_ff;
      pend_in     = pend_ff;
      rec_in      = rec_ff;
      pend_rec_in = pend_rec_ff;
      if (load) begin
         if (pend_ff) begin
            rec_in   = pend_rec_ff;
            pend_in  = 1'b0;
            valid_in = 1'b1;
         end else if (!q_empty) begin
            rec_in      = q_head.rec_a;
            pend_rec_in = q_head.rec_b;
            pend_in     = q_head.two;
            valid_in    = 1'b1;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff      <= rec_in;
      pend_rec_ff <= pend_rec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rec   = rec_ff;

`include "rgb565_run_length_encoder_core_assert.svh"

   `RLE565_ASSERT_IMPL(a_pend_needs_valid, clock, reset, pend_ff, valid_ff, "second result pending without a first one shown")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the rgb565 run-length encoder core
`timescale 1ns / 1ps

module testbench;

   import rle565_pkg::*;

   // ---------------------------------------------------------------------------
   // constants
   // ---------------------------------------------------------------------------
   localparam int RUN_LIMIT    = 255;     // longest run the block may report
   localparam int RANDOM_ITEMS = 1100;    // pixels in the random part
   localparam int SETTLE_CYCLES = 6;      // idle padding once every owed record is back
   localparam int STALL_LIMIT  = 1000;    // cycles with no beat on either side
   localparam int ROW_COUNT    = 25;

   // byte address of output_capacity on the apb port
   localparam logic [CSR_ADDR_W-1:0] ADDR_CAPACITY = '0;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_CADENCE
   } ready_mode_type;

   // one pixel beat plus, for directed rows, the records typed in by hand
   typedef struct {
      logic [COLOR_W-1:0] color;
      logic               last;
      bit                 typed;
      int                 n_typed;
      rec_type            r0;
      rec_type            r1;
   } pixel_beat_type;

   // one row of the directed part
   typedef struct {
      logic [BYTES_W-1:0] cap;
      pixel_beat_type     beat;
   } dir_row_type;

   // ---------------------------------------------------------------------------
   // dut signals, every input known from time zero
   // ---------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [COLOR_W-1:0]    req_pixel_color = '0;
   logic                  req_frame_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [LEN_W-1:0]      rsp_run_length;
   logic [COLOR_W-1:0]    rsp_run_color;
   logic                  rsp_frame_done;
   logic                  rsp_overflow;
   logic [BYTES_W-1:0]    rsp_total_bytes;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   rgb565_run_length_encoder_core #(
      .MAX_RUN(RUN_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pixel_color(req_pixel_color),
      .req_frame_end(req_frame_end),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_run_length(rsp_run_length),
      .rsp_run_color(rsp_run_color),
      .rsp_frame_done(rsp_frame_done),
      .rsp_overflow(rsp_overflow),
      .rsp_total_bytes(rsp_total_bytes),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // 2 ns clock
   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------
   // encoder model state, mirrors the block's frame state
   // ---------------------------------------------------------------------------
   logic [BYTES_W-1:0] cfg_capacity = CAPACITY_RESET;
   logic               enc_open   = 1'b0;
   logic [COLOR_W-1:0] enc_color  = '0;
   logic [LEN_W-1:0]   enc_count  = '0;
   logic [BYTES_W:0]   enc_bytes  = '0;   // one spare bit for the capacity compare
   logic               enc_ovf    = 1'b0;

   pixel_beat_type pixel_q[$];     // pixels waiting to be driven
   rec_type        record_q[$];    // records the block still owes us
   int             fail_count = 0;
   int             items_sent = 0;

   function automatic rec_type make_rec(input logic [LEN_W-1:0] len,
                                        input logic [COLOR_W-1:0] color,
                                        input logic done, input logic ovf,
                                        input logic [BYTES_W-1:0] total);
      rec_type r;
      r.len   = len;
      r.color = color;
      r.done  = done;
      r.ovf   = ovf;
      r.total = total;
      return r;
   endfunction

   // book three bytes for a record, or mark the frame overflowed
   function automatic bit take_record();
      if (enc_bytes + (BYTES_W+1)'(REC_BYTES) > {1'b0, cfg_capacity}) begin
         enc_ovf = 1'b1;
         return 1'b0;
      end
      enc_bytes = enc_bytes + (BYTES_W+1)'(REC_BYTES);
      return 1'b1;
   endfunction

   // advance the encoder model by one pixel, return the records it causes
   function automatic int encode_pixel(input logic [COLOR_W-1:0] color,
                                       input logic last,
                                       output rec_type r0, output rec_type r1);
      rec_type outs[2];
      int      n;
      n = 0;
      outs[0] = '0;
      outs[1] = '0;
      if (!enc_ovf) begin
         if (!enc_open) begin
            // first pixel of a frame opens a run
            enc_open  = 1'b1;
            enc_color = color;
            enc_count = LEN_W'(1);
         end else if (color == enc_color && enc_count < RUN_LIMIT) begin
            enc_count = enc_count + 1'b1;
         end else begin
            // run broken by a new color or by hitting the run limit
            if (take_record()) begin
               outs[n] = make_rec(enc_count, enc_color, 1'b0, 1'b0, '0);
               n++;
            end
            enc_color = color;
            enc_count = LEN_W'(1);
         end
      end
      if (last) begin
         if (!enc_ovf && take_record())
            outs[n] = make_rec(enc_count, enc_color, 1'b1, 1'b0, enc_bytes[BYTES_W-1:0]);
         else
            outs[n] = make_rec('0, '0, 1'b1, 1'b1, '0);   // overflow-only beat
         n++;
         enc_open  = 1'b0;
         enc_color = '0;
         enc_count = '0;
         enc_bytes = '0;
         enc_ovf   = 1'b0;
      end
      r0 = outs[0];
      r1 = outs[1];
      return n;
   endfunction

   // ---------------------------------------------------------------------------
   // pixel sender: records accepted beats, then presents the next one
   // bursts of random length with random gaps in between
   // ---------------------------------------------------------------------------
   pixel_beat_type shown_beat;
   int             burst_left = 1;
   int             gap_left   = 0;
   rec_type        pred_r0, pred_r1;
   int             pred_n;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // the beat on the bus was taken at this edge
         if (req_valid && req_ready) begin
            pred_n = encode_pixel(shown_beat.color, shown_beat.last, pred_r0, pred_r1);
            if (shown_beat.typed) begin
               // hand-typed rows override the model's records
               pred_n  = shown_beat.n_typed;
               pred_r0 = shown_beat.r0;
               pred_r1 = shown_beat.r1;
            end
            if (pred_n > 0) record_q.push_back(pred_r0);
            if (pred_n > 1) record_q.push_back(pred_r1);
         end
         // bus is free for a new beat
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
               shown_beat = pixel_q.pop_front();
               req_valid       <= 1'b1;
               req_pixel_color <= shown_beat.color;
               req_frame_end   <= shown_beat.last;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                           : $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // record receiver: ready follows a mode that changes now and then
   // ---------------------------------------------------------------------------
   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left  = 50;
   int             cadence    = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left <= 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(30, 200);
         end
         mode_left--;
         cadence++;
         case (ready_mode)
            READY_ALWAYS:  rsp_ready <= 1'b1;
            READY_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:  rsp_ready <= ($urandom_range(0, 7) == 0);
            default:       rsp_ready <= (cadence % 3 != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // record checker, oldest expectation first
   // ---------------------------------------------------------------------------
   rec_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (record_q.size() == 0) begin
            $error("record beat with nothing expected: run_length %0d run_color %h",
                   rsp_run_length, rsp_run_color);
            fail_count++;
         end else begin
            want = record_q.pop_front();
            if (rsp_run_length !== want.len) begin
               $error("run_length: expected %0d, got %0d", want.len, rsp_run_length);
               fail_count++;
            end
            if (rsp_run_color !== want.color) begin
               $error("run_color: expected %h, got %h", want.color, rsp_run_color);
               fail_count++;
            end
            if (rsp_frame_done !== want.done) begin
               $error("frame_done: expected %b, got %b", want.done, rsp_frame_done);
               fail_count++;
            end
            if (rsp_overflow !== want.ovf) begin
               $error("overflow: expected %b, got %b", want.ovf, rsp_overflow);
               fail_count++;
            end
            if (rsp_total_bytes !== want.total) begin
               $error("total_bytes: expected %0d, got %0d", want.total, rsp_total_bytes);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: too long with no beat on either channel
   // ---------------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   logic [COLOR_W-1:0] palette[4];

   task automatic queue_pixel(input logic [COLOR_W-1:0] color, input logic last);
      pixel_beat_type b;
      b.color   = color;
      b.last    = last;
      b.typed   = 1'b0;
      b.n_typed = 0;
      b.r0      = '0;
      b.r1      = '0;
      pixel_q.push_back(b);
      items_sent++;
   endtask

   // caller waits until every owed record is back and the pipe is empty
   task automatic wait_idle();
      do @(negedge clock);
      while (pixel_q.size() != 0 || req_valid || record_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // apb write: setup, then access; lands at the edge with penable high
   task automatic write_capacity(input logic [BYTES_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_CAPACITY;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cfg_capacity = value;
      // read back the register once the write has landed
      @(negedge clock);
      if (!pready || prdata !== CSR_DATA_W'(value)) begin
         $error("output_capacity: expected %h, got %h", value, prdata);
         fail_count++;
      end
   endtask

   // one random frame: mostly runs drawn from a small palette, sometimes noise
   task automatic queue_frame();
      int                 runs;
      int                 len;
      logic [COLOR_W-1:0] color;
      if ($urandom_range(0, 9) == 0) begin
         // noise: short bursts with frame ends sprinkled anywhere
         len = $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            color = ($urandom_range(0, 1) == 0) ? palette[$urandom_range(0, 3)]
                                                : COLOR_W'($urandom);
            queue_pixel(color, (i == len - 1) || ($urandom_range(0, 4) == 0));
         end
      end else begin
         runs = $urandom_range(1, 10);
         for (int r = 0; r < runs; r++) begin
            color = ($urandom_range(0, 1) == 0) ? palette[$urandom_range(0, 3)]
                                                : COLOR_W'($urandom);
            // a rare run near the length limit
            len = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 260)
                                               : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
               queue_pixel(color, (r == runs - 1) && (k == len - 1));
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // directed table: capacity, pixel, frame end, records typed in where obvious
   // ---------------------------------------------------------------------------
   dir_row_type dir_rows[ROW_COUNT];

   function automatic dir_row_type dir_row(input logic [BYTES_W-1:0] cap,
                                           input logic [COLOR_W-1:0] color,
                                           input logic last, input bit typed,
                                           input int n, input rec_type r0,
                                           input rec_type r1);
      dir_row_type row;
      row.cap          = cap;
      row.beat.color   = color;
      row.beat.last    = last;
      row.beat.typed   = typed;
      row.beat.n_typed = n;
      row.beat.r0      = r0;
      row.beat.r1      = r1;
      return row;
   endfunction

   initial begin
      logic [BYTES_W-1:0] cap;
      int                 phase;
      int                 frames;
      rec_type            none;
      rec_type            ovf_only;

      none     = '0;
      ovf_only = make_rec('0, '0, 1'b1, 1'b1, '0);

      // full capacity: single pixel frames at the color extremes
      dir_rows[0]  = dir_row('1, 16'hFFFF, 1'b1, 1'b1, 1,
                             make_rec(8'd1, 16'hFFFF, 1'b1, 1'b0, 24'd3), none);
      dir_rows[1]  = dir_row('1, 16'h0000, 1'b1, 1'b1, 1,
                             make_rec(8'd1, 16'h0000, 1'b1, 1'b0, 24'd3), none);
      // run broken and final flush in one beat
      dir_rows[2]  = dir_row('1, 16'h1234, 1'b0, 1'b1, 0, none, none);
      dir_rows[3]  = dir_row('1, 16'h1234, 1'b0, 1'b1, 0, none, none);
      dir_rows[4]  = dir_row('1, 16'hABCD, 1'b1, 1'b1, 2,
                             make_rec(8'd2, 16'h1234, 1'b0, 1'b0, 24'd0),
                             make_rec(8'd1, 16'hABCD, 1'b1, 1'b0, 24'd6));
      dir_rows[5]  = dir_row('1, 16'h5555, 1'b0, 1'b1, 0, none, none);
      dir_rows[6]  = dir_row('1, 16'hAAAA, 1'b0, 1'b1, 1,
                             make_rec(8'd1, 16'h5555, 1'b0, 1'b0, 24'd0), none);
      dir_rows[7]  = dir_row('1, 16'hAAAA, 1'b0, 1'b1, 0, none, none);
      dir_rows[8]  = dir_row('1, 16'hAAAA, 1'b1, 1'b1, 1,
                             make_rec(8'd3, 16'hAAAA, 1'b1, 1'b0, 24'd6), none);
      dir_rows[9]  = dir_row('1, 16'h8001, 1'b0, 1'b0, 0, none, none);
      dir_rows[10] = dir_row('1, 16'h7FFE, 1'b0, 1'b0, 0, none, none);
      dir_rows[11] = dir_row('1, 16'h8001, 1'b1, 1'b0, 0, none, none);
      // zero capacity: every frame ends overflow-only
      dir_rows[12] = dir_row('0, 16'h0001, 1'b1, 1'b1, 1, ovf_only, none);
      dir_rows[13] = dir_row('0, 16'h0002, 1'b0, 1'b1, 0, none, none);
      dir_rows[14] = dir_row('0, 16'h0003, 1'b0, 1'b1, 0, none, none);
      dir_rows[15] = dir_row('0, 16'h0003, 1'b1, 1'b1, 1, ovf_only, none);
      // room for exactly one record
      dir_rows[16] = dir_row(24'd3, 16'h7777, 1'b1, 1'b1, 1,
                             make_rec(8'd1, 16'h7777, 1'b1, 1'b0, 24'd3), none);
      dir_rows[17] = dir_row(24'd3, 16'h0001, 1'b0, 1'b1, 0, none, none);
      dir_rows[18] = dir_row(24'd3, 16'h0002, 1'b0, 1'b1, 1,
                             make_rec(8'd1, 16'h0001, 1'b0, 1'b0, 24'd0), none);
      dir_rows[19] = dir_row(24'd3, 16'h0003, 1'b0, 1'b1, 0, none, none);
      dir_rows[20] = dir_row(24'd3, 16'h0004, 1'b1, 1'b1, 1, ovf_only, none);
      // final record does not fit, overflow-only beat in its place
      dir_rows[21] = dir_row(24'd3, 16'h0001, 1'b0, 1'b1, 0, none, none);
      dir_rows[22] = dir_row(24'd3, 16'h0002, 1'b1, 1'b1, 2,
                             make_rec(8'd1, 16'h0001, 1'b0, 1'b0, 24'd0), ovf_only);
      // room for exactly two records
      dir_rows[23] = dir_row(24'd6, 16'h00FF, 1'b0, 1'b1, 0, none, none);
      dir_rows[24] = dir_row(24'd6, 16'hFF00, 1'b1, 1'b1, 2,
                             make_rec(8'd1, 16'h00FF, 1'b0, 1'b0, 24'd0),
                             make_rec(8'd1, 16'hFF00, 1'b1, 1'b0, 24'd6));

      // reset held once, at the start
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, capacity rewritten only with the block idle
      for (int i = 0; i < ROW_COUNT; i++) begin
         if (i == 0 || dir_rows[i].cap != cfg_capacity) begin
            wait_idle();
            write_capacity(dir_rows[i].cap);
         end
         pixel_q.push_back(dir_rows[i].beat);
         items_sent++;
      end

      // random part in phases, each with its own capacity
      phase = 0;
      while (items_sent < ROW_COUNT + RANDOM_ITEMS) begin
         wait_idle();
         case (phase)
            0: cap = '1;
            1: cap = '0;
            2: cap = BYTES_W'($urandom);
            default: begin
               case ($urandom_range(0, 4))
                  0: cap = '1;
                  1: cap = BYTES_W'(REC_BYTES * $urandom_range(1, 12));
                  2: cap = BYTES_W'($urandom_range(0, 40));
                  3: cap = BYTES_W'($urandom);
                  default: cap = '1 - BYTES_W'($urandom_range(0, 2));
               endcase
            end
         endcase
         write_capacity(cap);
         for (int p = 0; p < 4; p++)
            palette[p] = ($urandom_range(0, 5) == 0) ? {COLOR_W{p[0]}} : COLOR_W'($urandom);

         // first phase opens with a run well past the length limit
         if (phase == 0) begin
            for (int k = 0; k < 300; k++)
               queue_pixel(palette[0], k == 299);
         end

         frames = $urandom_range(3, 10);
         for (int f = 0; f < frames; f++) begin
            if (items_sent >= ROW_COUNT + RANDOM_ITEMS)
               break;
            if ($urandom_range(0, 7) == 0)
               wait_idle();
            queue_frame();
         end
         phase++;
      end

      // drain, then let the pipe settle
      wait_idle();
      if (fail_count == 0 && record_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
